/* hdl/rsr_pkg.sv */
// ---------------------------------------------------------------------------
// rsr_pkg: shared types and constants of the rule syntax recognizer
// character constants, byte classes, recognizer states and queue types
// ---------------------------------------------------------------------------
package rsr_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int FIELD_WIDTH = 16;
   localparam int CODE_WIDTH  = 6;
   localparam int BYTE_WIDTH  = 8;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   localparam logic [BYTE_WIDTH-1:0] CH_TAB     = 8'h09;
   localparam logic [BYTE_WIDTH-1:0] CH_NEWLINE = 8'h0A;
   localparam logic [BYTE_WIDTH-1:0] CH_SPACE   = 8'h20;
   localparam logic [BYTE_WIDTH-1:0] CH_HASH    = 8'h23;
   localparam logic [BYTE_WIDTH-1:0] CH_DOLLAR  = 8'h24;
   localparam logic [BYTE_WIDTH-1:0] CH_QUOTE   = 8'h27;
   localparam logic [BYTE_WIDTH-1:0] CH_LPAREN  = 8'h28;
   localparam logic [BYTE_WIDTH-1:0] CH_RPAREN  = 8'h29;
   localparam logic [BYTE_WIDTH-1:0] CH_COMMA   = 8'h2C;
   localparam logic [BYTE_WIDTH-1:0] CH_SEMI    = 8'h3B;
   localparam logic [BYTE_WIDTH-1:0] CH_AT      = 8'h40;
   localparam logic [BYTE_WIDTH-1:0] CH_BSLASH  = 8'h5C;
   localparam logic [BYTE_WIDTH-1:0] CH_LBRACE  = 8'h7B;
   localparam logic [BYTE_WIDTH-1:0] CH_PIPE    = 8'h7C;
   localparam logic [BYTE_WIDTH-1:0] CH_RBRACE  = 8'h7D;

   typedef enum logic [3:0] {
      CC_OTHER,
      CC_SPACE,
      CC_NEWLINE,
      CC_HASH,
      CC_DOLLAR,
      CC_BSLASH,
      CC_LBRACE,
      CC_RBRACE,
      CC_PIPE,
      CC_AT,
      CC_LPAREN,
      CC_RPAREN,
      CC_SEMI,
      CC_COMMA,
      CC_QUOTE
   } char_class_type;

   // recognizer states; error codes are two's complement of -1 .. -14
   typedef enum logic [CODE_WIDTH-1:0] {
      S_TOP        = 6'd0,
      S_COMMENT    = 6'd1,
      S_NAME_OPEN  = 6'd2,
      S_NAME       = 6'd3,
      S_NAME_ESC   = 6'd4,
      S_AFTER_NAME = 6'd5,
      S_SET_ITEM   = 6'd6,
      S_SET_OPEN   = 6'd7,
      S_SET_SYM    = 6'd8,
      S_SET_ESC    = 6'd9,
      S_SET_CLOSE  = 6'd10,
      S_AFTER_SET  = 6'd11,
      S_EPS_CLOSE  = 6'd12,
      S_TRANS      = 6'd13,
      S_LIST_ITEM  = 6'd14,
      S_LIST_OPEN  = 6'd15,
      S_LIST_SYM   = 6'd16,
      S_LIST_ESC   = 6'd17,
      S_LIST_CLOSE = 6'd18,
      S_LIST_NEXT  = 6'd19,
      S_AFTER_LIST = 6'd20,
      S_TGT_OPEN   = 6'd21,
      S_TGT        = 6'd22,
      S_TGT_ESC    = 6'd23,
      S_AFTER_TGT  = 6'd24,
      E_BAD_START  = 6'd63,
      E_EMPTY_NAME = 6'd62,
      E_AFTER_NAME = 6'd61,
      E_SET_ITEM   = 6'd60,
      E_EMPTY_SYM  = 6'd59,
      E_SET_CLOSE  = 6'd58,
      E_AFTER_SET  = 6'd57,
      E_EPS_CLOSE  = 6'd56,
      E_NO_PAREN   = 6'd55,
      E_LIST_ITEM  = 6'd54,
      E_LIST_CLOSE = 6'd53,
      E_LIST_NEXT  = 6'd52,
      E_NO_TARGET  = 6'd51,
      E_AFTER_TGT  = 6'd50
   } rsr_state_type;

   typedef struct packed {
      char_class_type char_class;
      logic           restart;
   } queue_entry_type;

   typedef struct packed {
      logic              full;
      logic              empty;
      logic [QUEUE_AW:0] count;
   } queue_status_type;

endpackage

/* hdl/rsr_channels.sv */
// ---------------------------------------------------------------------------
// rsr channels: valid/ready interfaces of the rule syntax recognizer
// one interface for text bytes in, one for recognizer results out
// ---------------------------------------------------------------------------
interface rsr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       start_of_stream;

   modport source (output valid, output text_byte, output start_of_stream, input ready);
   modport sink   (input valid, input text_byte, input start_of_stream, output ready);
endinterface

interface rsr_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [5:0] state_code;
   logic [15:0]       row_number;
   logic [15:0]       column_number;

   modport source (output valid, output state_code, output row_number,
                   output column_number, input ready);
   modport sink   (input valid, input state_code, input row_number,
                   input column_number, output ready);
endinterface

/* hdl/rsr_front.sv */
// ---------------------------------------------------------------------------
// rsr_front: byte intake and classification
// maps each accepted text byte to a grammar class and pushes it to the queue
// ---------------------------------------------------------------------------
module rsr_front (
   rsr_req_if.sink                  req_if,
   input  rsr_pkg::queue_status_type q_status,
   output logic                     push_valid,
   output rsr_pkg::queue_entry_type push_entry
);
   import rsr_pkg::*;

   function automatic char_class_type classify(logic [BYTE_WIDTH-1:0] b);
      char_class_type c;
      unique case (b)
         CH_SPACE, CH_TAB: c = CC_SPACE;
         CH_NEWLINE:       c = CC_NEWLINE;
         CH_HASH:          c = CC_HASH;
         CH_DOLLAR:        c = CC_DOLLAR;
         CH_BSLASH:        c = CC_BSLASH;
         CH_LBRACE:        c = CC_LBRACE;
         CH_RBRACE:        c = CC_RBRACE;
         CH_PIPE:          c = CC_PIPE;
         CH_AT:            c = CC_AT;
         CH_LPAREN:        c = CC_LPAREN;
         CH_RPAREN:        c = CC_RPAREN;
         CH_SEMI:          c = CC_SEMI;
         CH_COMMA:         c = CC_COMMA;
         CH_QUOTE:         c = CC_QUOTE;
         default:          c = CC_OTHER;
      endcase
      return c;
   endfunction

   assign req_if.ready          = !q_status.full;
   assign push_valid            = req_if.valid && !q_status.full;
   assign push_entry.char_class = classify(req_if.text_byte);
   assign push_entry.restart    = req_if.start_of_stream;

endmodule

/* hdl/rsr_queue.sv */
// ---------------------------------------------------------------------------
// rsr_queue: short fifo between front and back
// holds classified words so each side can stall on its own
// ---------------------------------------------------------------------------
module rsr_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  rsr_pkg::queue_entry_type  push_entry,
   input  logic                      pop,
   output rsr_pkg::queue_entry_type  head,
   output rsr_pkg::queue_status_type q_status
);
   import rsr_pkg::*;

   localparam logic [QUEUE_AW:0] DEPTH_COUNT = (QUEUE_AW+1)'(QUEUE_DEPTH);
   localparam logic [QUEUE_AW-1:0] LAST_SLOT = QUEUE_AW'(QUEUE_DEPTH - 1);

   queue_entry_type      slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head           = slot_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == DEPTH_COUNT);
   assign q_status.empty = (count_ff == '0);
   assign q_status.count = count_ff;

endmodule

/* hdl/rsr_back.sv */
// ---------------------------------------------------------------------------
// rsr_back: recognizer state machine and position counters
// takes one word per cycle unless a result is stalled; holds it until taken
// ---------------------------------------------------------------------------
module rsr_back (
   input  logic                      clock,
   input  logic                      reset,
   input  rsr_pkg::queue_entry_type  head,
   input  rsr_pkg::queue_status_type q_status,
   output logic                      pop,
   rsr_rsp_if.source                 rsp_if
);
   import rsr_pkg::*;

   rsr_state_type            state_ff, state_in, base_state;
   logic [COUNT_WIDTH-1:0]   row_ff, row_in, base_row;
   logic [COUNT_WIDTH-1:0]   col_ff, col_in, base_col;
   logic                     out_valid_ff, out_valid_in;
   logic                     blank;
   char_class_type           cc;

   assign pop   = !q_status.empty && (!out_valid_ff || rsp_if.ready);
   assign cc    = head.char_class;
   assign blank = (cc == CC_SPACE) || (cc == CC_NEWLINE);

   always_comb begin
      base_state = head.restart ? S_TOP : state_ff;
      base_row   = head.restart ? COUNT_WIDTH'(1) : row_ff;
      base_col   = head.restart ? '0 : col_ff;

      if (cc == CC_NEWLINE) begin
         row_in = (base_row != COUNT_MAX) ? base_row + 1'b1 : base_row;
         col_in = COUNT_WIDTH'(1);
      end else begin
         row_in = base_row;
         col_in = (base_col != COUNT_MAX) ? base_col + 1'b1 : base_col;
      end

      unique case (base_state)
         S_TOP:
            if (blank) state_in = S_TOP;
            else if (cc == CC_HASH) state_in = S_COMMENT;
            else if (cc == CC_DOLLAR) state_in = S_NAME_OPEN;
            else state_in = E_BAD_START;
         S_COMMENT:
            state_in = (cc == CC_NEWLINE) ? S_TOP : S_COMMENT;
         S_NAME_OPEN:
            if (cc == CC_BSLASH) state_in = S_NAME_ESC;
            else if (cc == CC_DOLLAR) state_in = E_EMPTY_NAME;
            else state_in = S_NAME;
         S_NAME:
            if (cc == CC_BSLASH) state_in = S_NAME_ESC;
            else if (cc == CC_DOLLAR) state_in = S_AFTER_NAME;
            else state_in = S_NAME;
         S_NAME_ESC:
            state_in = (cc == CC_DOLLAR) ? S_AFTER_NAME : S_NAME;
         S_AFTER_NAME:
            if (cc == CC_SEMI) state_in = S_TOP;
            else if (blank) state_in = S_AFTER_NAME;
            else if (cc == CC_LBRACE) state_in = S_SET_ITEM;
            else if (cc == CC_PIPE) state_in = S_TRANS;
            else state_in = E_AFTER_NAME;
         S_SET_ITEM:
            if (blank) state_in = S_SET_ITEM;
            else if (cc == CC_QUOTE) state_in = S_SET_OPEN;
            else if (cc == CC_RBRACE) state_in = S_AFTER_SET;
            else state_in = E_SET_ITEM;
         S_SET_OPEN:
            if (cc == CC_BSLASH) state_in = S_SET_ESC;
            else if (cc == CC_QUOTE) state_in = E_EMPTY_SYM;
            else state_in = S_SET_SYM;
         S_SET_SYM:
            if (cc == CC_BSLASH) state_in = S_SET_ESC;
            else if (cc == CC_QUOTE) state_in = S_SET_CLOSE;
            else state_in = S_SET_SYM;
         S_SET_ESC:
            state_in = (cc == CC_QUOTE) ? S_SET_CLOSE : S_SET_SYM;
         S_SET_CLOSE:
            if (cc == CC_COMMA) state_in = S_SET_ITEM;
            else if (blank) state_in = S_SET_CLOSE;
            else if (cc == CC_RBRACE) state_in = S_AFTER_SET;
            else state_in = E_SET_CLOSE;
         S_AFTER_SET:
            if (cc == CC_SEMI) state_in = S_TOP;
            else if (blank) state_in = S_AFTER_SET;
            else if (cc == CC_PIPE) state_in = S_TRANS;
            else state_in = E_AFTER_SET;
         S_EPS_CLOSE:
            if (blank) state_in = S_EPS_CLOSE;
            else if (cc == CC_RPAREN) state_in = S_AFTER_LIST;
            else state_in = E_EPS_CLOSE;
         S_TRANS:
            if (blank) state_in = S_TRANS;
            else if (cc == CC_LPAREN) state_in = S_LIST_ITEM;
            else state_in = E_NO_PAREN;
         S_LIST_ITEM:
            if (cc == CC_AT) state_in = S_EPS_CLOSE;
            else if (blank) state_in = S_LIST_ITEM;
            else if (cc == CC_QUOTE) state_in = S_LIST_OPEN;
            else state_in = E_LIST_ITEM;
         S_LIST_OPEN:
            state_in = (cc == CC_BSLASH) ? S_LIST_ESC : S_LIST_SYM;
         S_LIST_SYM:
            if (cc == CC_BSLASH) state_in = S_LIST_ESC;
            else if (cc == CC_QUOTE) state_in = S_LIST_CLOSE;
            else state_in = S_LIST_SYM;
         S_LIST_ESC:
            state_in = (cc == CC_QUOTE) ? S_LIST_CLOSE : S_LIST_ESC;
         S_LIST_CLOSE:
            if (blank) state_in = S_LIST_CLOSE;
            else if (cc == CC_COMMA) state_in = S_LIST_NEXT;
            else if (cc == CC_RPAREN) state_in = S_AFTER_LIST;
            else state_in = E_LIST_CLOSE;
         S_LIST_NEXT:
            if (cc == CC_QUOTE) state_in = S_LIST_OPEN;
            else if (blank) state_in = S_LIST_NEXT;
            else state_in = E_LIST_NEXT;
         S_AFTER_LIST:
            if (blank) state_in = S_AFTER_LIST;
            else if (cc == CC_DOLLAR) state_in = S_TGT_OPEN;
            else state_in = E_NO_TARGET;
         S_TGT_OPEN:
            state_in = (cc == CC_BSLASH) ? S_TGT_ESC : S_TGT;
         S_TGT:
            if (cc == CC_BSLASH) state_in = S_TGT_ESC;
            else if (cc == CC_DOLLAR) state_in = S_AFTER_TGT;
            else state_in = S_TGT;
         S_TGT_ESC:
            state_in = (cc == CC_DOLLAR) ? S_AFTER_TGT : S_TGT;
         S_AFTER_TGT:
            if (cc == CC_SEMI) state_in = S_TOP;
            else if (cc == CC_COMMA) state_in = S_TRANS;
            else if (blank) state_in = S_AFTER_TGT;
            else state_in = E_AFTER_TGT;
         default:
            state_in = base_state;   // error codes hold
      endcase

      out_valid_in = out_valid_ff;
      if (pop) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_TOP;
         row_ff       <= COUNT_WIDTH'(1);
         col_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (pop) begin
            state_ff <= state_in;
            row_ff   <= row_in;
            col_ff   <= col_in;
         end
      end
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.state_code    = state_ff;
   assign rsp_if.row_number    = FIELD_WIDTH'(row_ff);
   assign rsp_if.column_number = FIELD_WIDTH'(col_ff);

endmodule

/* hdl/rule_syntax_recognizer.sv */
// path: a word is queued, then its result is registered in the back end
// throughput: one text byte per cycle while the result receiver stays ready;
//    the front takes words while a result waits, until the queue is full
// reset: synchronous; empties the queue, drops any pending result, and puts
//    the recognizer in the top state with row 1 and column 0
// ---------------------------------------------------------------------------
// rule_syntax_recognizer: streaming syntax check of transition rule text
// front classifies bytes, a short queue decouples it from the back end,
// which runs the recognizer and row/column counters
// ---------------------------------------------------------------------------
module rule_syntax_recognizer (
   input logic       clock,
   input logic       reset,
   rsr_req_if.sink   req_if,
   rsr_rsp_if.source rsp_if
);
   import rsr_pkg::*;

   // front to queue
   logic             push_valid;
   queue_entry_type  push_entry;

   // queue to back
   queue_entry_type  queue_head;
   queue_status_type q_status;
   logic             back_pop;

   // intake: a word is pushed whenever one is offered and the queue has room
   rsr_front u_front (
      .req_if     (req_if),
      .q_status   (q_status),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   // decoupling fifo, push and pop may happen in the same cycle
   rsr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (back_pop),
      .head       (queue_head),
      .q_status   (q_status)
   );

   // recognizer and counters; result register doubles as output stage
   rsr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (queue_head),
      .q_status (q_status),
      .pop      (back_pop),
      .rsp_if   (rsp_if)
   );

`ifndef ASSERT_OFF
   // fill level never passes the queue depth
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
      else $error("queue fill level beyond depth");

   // back end only consumes words that are really queued
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      back_pop |-> !q_status.empty)
      else $error("pop from empty queue");

   // an error code stays until a new stream starts
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (back_pop && !queue_head.restart && rsp_if.state_code[CODE_WIDTH-1])
      |=> $stable(rsp_if.state_code))
      else $error("error code left without stream restart");

   // reset leaves nothing pending and the intake open
   a_reset_clean: assert property (@(posedge clock)
      reset |=> (!rsp_if.valid && req_if.ready))
      else $error("state left pending across reset");
`endif

endmodule

/* verif/rule_syntax_recognizer_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rule_syntax_recognizer_tb: self-checking bench for the rule syntax recognizer
// streams rule text with random valid/ready gaps, predicts state/row/column
// per word and compares every result word against the prediction in order
// ---------------------------------------------------------------------------
module rule_syntax_recognizer_tb;
   import rsr_pkg::*;

   localparam int IDLE_PERCENT   = 35;
   localparam int RANDOM_WORDS   = 600;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 10;
   localparam int REPORT_LIMIT   = 10;

   // one expected result word: state code plus row/column position
   typedef struct packed {
      logic [CODE_WIDTH-1:0]  code;
      logic [FIELD_WIDTH-1:0] row;
      logic [FIELD_WIDTH-1:0] col;
   } cursor_status_type;

   // ------------------------------------------------------------------------
   // scoreboard: tracks the grammar position and text cursor of the stream
   // ------------------------------------------------------------------------
   class syntax_scoreboard;
      rsr_state_type          state;
      logic [COUNT_WIDTH-1:0] row_cnt;
      logic [COUNT_WIDTH-1:0] col_cnt;
      cursor_status_type      status_q[$];
      int                     mismatches;

      function new();
         state      = S_TOP;
         row_cnt    = COUNT_WIDTH'(1);
         col_cnt    = '0;
         mismatches = 0;
      endfunction

      function bit is_blank(logic [7:0] c);
         return c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE;
      endfunction

      // one step of the rule grammar; error states never leave
      function rsr_state_type advance_recognizer(rsr_state_type s, logic [7:0] c);
         rsr_state_type n;
         n = s;
         case (s)
            S_TOP: begin
               if (is_blank(c)) n = S_TOP;
               else if (c == CH_HASH) n = S_COMMENT;
               else if (c == CH_DOLLAR) n = S_NAME_OPEN;
               else n = E_BAD_START;
            end
            S_COMMENT:   n = (c == CH_NEWLINE) ? S_TOP : S_COMMENT;
            S_NAME_OPEN: begin
               if (c == CH_BSLASH) n = S_NAME_ESC;
               else if (c == CH_DOLLAR) n = E_EMPTY_NAME;
               else n = S_NAME;
            end
            S_NAME: begin
               if (c == CH_BSLASH) n = S_NAME_ESC;
               else if (c == CH_DOLLAR) n = S_AFTER_NAME;
               else n = S_NAME;
            end
            S_NAME_ESC:  n = (c == CH_DOLLAR) ? S_AFTER_NAME : S_NAME;
            S_AFTER_NAME: begin
               if (c == CH_SEMI) n = S_TOP;
               else if (is_blank(c)) n = S_AFTER_NAME;
               else if (c == CH_LBRACE) n = S_SET_ITEM;
               else if (c == CH_PIPE) n = S_TRANS;
               else n = E_AFTER_NAME;
            end
            S_SET_ITEM: begin
               if (is_blank(c)) n = S_SET_ITEM;
               else if (c == CH_QUOTE) n = S_SET_OPEN;
               else if (c == CH_RBRACE) n = S_AFTER_SET;
               else n = E_SET_ITEM;
            end
            S_SET_OPEN: begin
               if (c == CH_BSLASH) n = S_SET_ESC;
               else if (c == CH_QUOTE) n = E_EMPTY_SYM;
               else n = S_SET_SYM;
            end
            S_SET_SYM: begin
               if (c == CH_BSLASH) n = S_SET_ESC;
               else if (c == CH_QUOTE) n = S_SET_CLOSE;
               else n = S_SET_SYM;
            end
            S_SET_ESC:   n = (c == CH_QUOTE) ? S_SET_CLOSE : S_SET_SYM;
            S_SET_CLOSE: begin
               if (c == CH_COMMA) n = S_SET_ITEM;
               else if (is_blank(c)) n = S_SET_CLOSE;
               else if (c == CH_RBRACE) n = S_AFTER_SET;
               else n = E_SET_CLOSE;
            end
            S_AFTER_SET: begin
               if (c == CH_SEMI) n = S_TOP;
               else if (is_blank(c)) n = S_AFTER_SET;
               else if (c == CH_PIPE) n = S_TRANS;
               else n = E_AFTER_SET;
            end
            S_EPS_CLOSE: begin
               if (is_blank(c)) n = S_EPS_CLOSE;
               else if (c == CH_RPAREN) n = S_AFTER_LIST;
               else n = E_EPS_CLOSE;
            end
            S_TRANS: begin
               if (is_blank(c)) n = S_TRANS;
               else if (c == CH_LPAREN) n = S_LIST_ITEM;
               else n = E_NO_PAREN;
            end
            S_LIST_ITEM: begin
               if (c == CH_AT) n = S_EPS_CLOSE;
               else if (is_blank(c)) n = S_LIST_ITEM;
               else if (c == CH_QUOTE) n = S_LIST_OPEN;
               else n = E_LIST_ITEM;
            end
            S_LIST_OPEN: n = (c == CH_BSLASH) ? S_LIST_ESC : S_LIST_SYM;
            S_LIST_SYM: begin
               if (c == CH_BSLASH) n = S_LIST_ESC;
               else if (c == CH_QUOTE) n = S_LIST_CLOSE;
               else n = S_LIST_SYM;
            end
            S_LIST_ESC:  n = (c == CH_QUOTE) ? S_LIST_CLOSE : S_LIST_ESC;
            S_LIST_CLOSE: begin
               if (is_blank(c)) n = S_LIST_CLOSE;
               else if (c == CH_COMMA) n = S_LIST_NEXT;
               else if (c == CH_RPAREN) n = S_AFTER_LIST;
               else n = E_LIST_CLOSE;
            end
            S_LIST_NEXT: begin
               if (c == CH_QUOTE) n = S_LIST_OPEN;
               else if (is_blank(c)) n = S_LIST_NEXT;
               else n = E_LIST_NEXT;
            end
            S_AFTER_LIST: begin
               if (is_blank(c)) n = S_AFTER_LIST;
               else if (c == CH_DOLLAR) n = S_TGT_OPEN;
               else n = E_NO_TARGET;
            end
            S_TGT_OPEN:  n = (c == CH_BSLASH) ? S_TGT_ESC : S_TGT;
            S_TGT: begin
               if (c == CH_BSLASH) n = S_TGT_ESC;
               else if (c == CH_DOLLAR) n = S_AFTER_TGT;
               else n = S_TGT;
            end
            S_TGT_ESC:   n = (c == CH_DOLLAR) ? S_AFTER_TGT : S_TGT;
            S_AFTER_TGT: begin
               if (c == CH_SEMI) n = S_TOP;
               else if (c == CH_COMMA) n = S_TRANS;
               else if (is_blank(c)) n = S_AFTER_TGT;
               else n = E_AFTER_TGT;
            end
            default: n = s;
         endcase
         return n;
      endfunction

      // accepted text word: move the cursor, then the grammar
      function void note_word(logic [7:0] c, logic sos);
         if (sos) begin
            state   = S_TOP;
            row_cnt = COUNT_WIDTH'(1);
            col_cnt = '0;
         end
         if (c == CH_NEWLINE) begin
            if (row_cnt != COUNT_MAX) row_cnt++;
            col_cnt = COUNT_WIDTH'(1);
         end else if (col_cnt != COUNT_MAX) begin
            col_cnt++;
         end
         state = advance_recognizer(state, c);
         status_q.push_back('{code: state, row: row_cnt[FIELD_WIDTH-1:0],
                              col: col_cnt[FIELD_WIDTH-1:0]});
      endfunction

      function void check_result(logic [CODE_WIDTH-1:0] code,
                                 logic [FIELD_WIDTH-1:0] row,
                                 logic [FIELD_WIDTH-1:0] col);
         cursor_status_type exp;
         if (status_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: result word with none expected: code %0d row %0d col %0d",
                        $realtime, $signed(code), row, col);
            return;
         end
         exp = status_q.pop_front();
         if (code !== exp.code || row !== exp.row || col !== exp.col) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: wrong result: expected code %0d row %0d col %0d,",
                        $realtime, $signed(exp.code), exp.row, exp.col,
                        " got code %0d row %0d col %0d",
                        $signed(code), row, col);
         end
      endfunction

      function int pending();
         return status_q.size();
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // clock, reset, channels and the block
   // ------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset;

   always #1 clock = ~clock;

   rsr_req_if req_bus ();
   rsr_rsp_if rsp_bus ();

   rule_syntax_recognizer dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   syntax_scoreboard sb;
   bit               quiet;          // no idling on either side while set
   bit               hold_request;   // asks the receiver for one long stall
   int               words_sent;
   int               idle_cycles;
   logic [7:0]       text_q[$];      // rule text of the stream being built

   initial sb = new();

   // ------------------------------------------------------------------------
   // monitor: notes accepted words, checks result words, runs the watchdog
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         // text word goes into the prediction before the result check, the
         // result of this edge belongs to an earlier word anyway
         if (req_bus.valid && req_bus.ready)
            sb.note_word(req_bus.text_byte, req_bus.start_of_stream);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_result(rsp_bus.state_code, rsp_bus.row_number,
                            rsp_bus.column_number);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("rule_syntax_recognizer: mismatch");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // receiver: random ready, one long stall on request so the queue fills
   // ------------------------------------------------------------------------
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end
         rsp_bus.ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // ------------------------------------------------------------------------
   // sender: one text word per call, entered and left at a falling edge
   // ------------------------------------------------------------------------
   task automatic send_word(logic [7:0] b, logic sos);
      while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.text_byte       <= b;
      req_bus.start_of_stream <= sos;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      words_sent++;
   endtask

   // first word of a stream restarts the recognizer
   task automatic send_stream();
      foreach (text_q[i]) send_word(text_q[i], i == 0);
   endtask

   // ------------------------------------------------------------------------
   // rule text generation
   // ------------------------------------------------------------------------
   function automatic logic [7:0] any_except(logic [7:0] a, logic [7:0] b);
      logic [7:0] c;
      do c = 8'($urandom_range(255)); while (c == a || c == b);
      return c;
   endfunction

   function automatic logic [7:0] pick_mark();
      case ($urandom_range(13))
         0:  return CH_HASH;
         1:  return CH_DOLLAR;
         2:  return CH_QUOTE;
         3:  return CH_LPAREN;
         4:  return CH_RPAREN;
         5:  return CH_COMMA;
         6:  return CH_SEMI;
         7:  return CH_AT;
         8:  return CH_BSLASH;
         9:  return CH_LBRACE;
         10: return CH_PIPE;
         11: return CH_RBRACE;
         12: return CH_NEWLINE;
         default: return CH_SPACE;
      endcase
   endfunction

   function automatic void put_blanks();
      int n;
      n = $urandom_range(2);
      repeat (n) begin
         case ($urandom_range(2))
            0: text_q.push_back(CH_SPACE);
            1: text_q.push_back(CH_TAB);
            default: text_q.push_back(CH_NEWLINE);
         endcase
      end
   endfunction

   // state names, targets and set symbols: delimited, backslash escapes one byte
   function automatic void put_quoted(logic [7:0] delim);
      int n;
      n = $urandom_range(1, 4);
      text_q.push_back(delim);
      repeat (n) begin
         if ($urandom_range(4) == 0) begin
            text_q.push_back(CH_BSLASH);
            text_q.push_back(any_except(delim, delim));
         end else begin
            text_q.push_back(any_except(CH_BSLASH, delim));
         end
      end
      text_q.push_back(delim);
   endfunction

   // transition symbol: an escape runs on to the closing quote
   function automatic void put_list_symbol();
      int n;
      n = $urandom_range(0, 3);
      text_q.push_back(CH_QUOTE);
      if (n == 0) text_q.push_back(any_except(CH_BSLASH, CH_BSLASH));
      repeat (n) text_q.push_back(any_except(CH_BSLASH, CH_QUOTE));
      if ($urandom_range(3) == 0) begin
         text_q.push_back(CH_BSLASH);
         repeat ($urandom_range(2)) text_q.push_back(any_except(CH_QUOTE, CH_QUOTE));
      end
      text_q.push_back(CH_QUOTE);
   endfunction

   function automatic void put_set();
      text_q.push_back(CH_LBRACE);
      put_blanks();
      if ($urandom_range(4) != 0) begin
         put_quoted(CH_QUOTE);
         repeat ($urandom_range(2)) begin
            put_blanks();
            text_q.push_back(CH_COMMA);
            put_blanks();
            put_quoted(CH_QUOTE);
         end
         put_blanks();
      end
      text_q.push_back(CH_RBRACE);
   endfunction

   function automatic void put_transition();
      put_blanks();
      text_q.push_back(CH_LPAREN);
      put_blanks();
      if ($urandom_range(4) == 0) begin
         // epsilon move
         text_q.push_back(CH_AT);
         put_blanks();
      end else begin
         put_list_symbol();
         repeat ($urandom_range(2)) begin
            put_blanks();
            text_q.push_back(CH_COMMA);
            put_blanks();
            put_list_symbol();
         end
         put_blanks();
      end
      text_q.push_back(CH_RPAREN);
      put_blanks();
      put_quoted(CH_DOLLAR);
      put_blanks();
   endfunction

   function automatic void put_trans_list();
      text_q.push_back(CH_PIPE);
      put_transition();
      repeat ($urandom_range(2)) begin
         text_q.push_back(CH_COMMA);
         put_transition();
      end
   endfunction

   function automatic void put_rule();
      put_quoted(CH_DOLLAR);
      put_blanks();
      case ($urandom_range(3))
         0: ;
         1: begin
            put_set();
            put_blanks();
         end
         2: begin
            put_set();
            put_blanks();
            put_trans_list();
         end
         default: put_trans_list();
      endcase
      text_q.push_back(CH_SEMI);
   endfunction

   function automatic void put_comment();
      text_q.push_back(CH_HASH);
      repeat ($urandom_range(6)) text_q.push_back(any_except(CH_NEWLINE, CH_NEWLINE));
      text_q.push_back(CH_NEWLINE);
   endfunction

   // mostly well-formed streams; some get a damaged byte, a few are noise
   function automatic void build_stream();
      int pick;
      int idx;
      text_q.delete();
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(1, 12)) text_q.push_back(8'($urandom_range(255)));
         return;
      end
      repeat ($urandom_range(1, 4)) begin
         pick = $urandom_range(9);
         if (pick < 7) put_rule();
         else if (pick < 9) put_comment();
         else put_blanks();
      end
      if (text_q.size() == 0) text_q.push_back(CH_SPACE);
      if ($urandom_range(9) < 4) begin
         idx = $urandom_range(text_q.size() - 1);
         case ($urandom_range(2))
            0: text_q[idx] = 8'($urandom_range(255));
            1: text_q.insert(idx, pick_mark());
            default: text_q[idx] = pick_mark();
         endcase
      end
   endfunction

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      int base;
      bit stall_done;
      reset                   = 1'b1;
      quiet                   = 1'b0;
      hold_request            = 1'b0;
      stall_done              = 1'b0;
      words_sent              = 0;
      req_bus.valid           = 1'b0;
      req_bus.text_byte       = 8'h00;
      req_bus.start_of_stream = 1'b0;
      rsp_bus.ready           = 1'b0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: comment holding a zero byte and the top byte value, a name
      // with an escape, then an epsilon-free transition whose symbol has an
      // escape that swallows bytes up to the quote
      text_q = '{CH_HASH, 8'h00, 8'hFF, CH_NEWLINE,
                 CH_DOLLAR, CH_BSLASH, "q", CH_DOLLAR,
                 CH_PIPE, CH_LPAREN, CH_QUOTE, CH_BSLASH, "z", "y", CH_QUOTE,
                 CH_RPAREN, CH_DOLLAR, "T", CH_DOLLAR, CH_SEMI};
      send_stream();
      // bad start byte, then the error must hold through a legal byte
      text_q = '{8'h01, CH_DOLLAR};
      send_stream();
      // new stream clears the error
      text_q = '{CH_TAB};
      send_stream();

      // long comment line, then a run of newlines; no idling here, which is
      // the long gap-free stretch
      quiet = 1'b1;
      send_word(CH_HASH, 1'b1);
      repeat (60) send_word(any_except(CH_NEWLINE, CH_NEWLINE), 1'b0);
      repeat (20) send_word(CH_NEWLINE, 1'b0);
      quiet = 1'b0;

      // random rule streams, with one long receiver stall part way through
      base = words_sent;
      while (words_sent - base < RANDOM_WORDS) begin
         if (!stall_done && words_sent - base >= 200) begin
            hold_request = 1'b1;
            stall_done   = 1'b1;
         end
         build_stream();
         send_stream();
      end
      req_bus.valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("rule_syntax_recognizer: match");
      else
         $display("rule_syntax_recognizer: mismatch");
      $finish;
   end

endmodule
